@@ hw/rtl/button_hold_gesture_classifier_core_macros.svh @@
// assertion helpers for the button hold classifier
`ifndef BUTTON_HOLD_GESTURE_CLASSIFIER_CORE_MACROS_SVH
`define BUTTON_HOLD_GESTURE_CLASSIFIER_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define BHG_ASSERT_CLK(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define BHG_ASSERT(name, prop, msg) \
  `BHG_ASSERT_CLK(name, clk_i, rst_ni, prop, msg)
`else
`define BHG_ASSERT_CLK(name, clk, rst_n, prop, msg)
`define BHG_ASSERT(name, prop, msg)
`endif

`endif

@@ hw/rtl/bhgc_pkg.sv @@
`timescale 1ns / 1ps

package bhgc_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned HoldW    = 16;
  localparam int unsigned PhaseW   = 12;

  localparam logic [HoldW-1:0]  RefreshMsRst     = 16'd5000;
  localparam logic [HoldW-1:0]  MaintenanceMsRst = 16'd10000;
  localparam logic [HoldW-1:0]  ProvisionMsRst   = 16'd20000;
  localparam logic [PhaseW-1:0] PulseHalfMsRst   = 12'd200;
  localparam logic [PhaseW-1:0] BurstStepMsRst   = 12'd60;
  localparam logic [HoldW-1:0]  HoldMax          = 16'hFFFF;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_HOLD  = 2'd1,
    MODE_BURST = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    GEST_NONE    = 3'd0,
    GEST_TAP     = 3'd1,
    GEST_REFRESH = 3'd2,
    GEST_MAINT   = 3'd3,
    GEST_PROV    = 3'd4
  } gesture_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_REFRESH_MS     = 3'd0,
    REG_MAINTENANCE_MS = 3'd1,
    REG_PROVISION_MS   = 3'd2,
    REG_PULSE_HALF_MS  = 3'd3,
    REG_BURST_STEP_MS  = 3'd4
  } reg_idx_e;

  typedef enum logic {
    ACT_BOOT_CHECK = 1'b0,
    ACT_TICK       = 1'b1
  } action_e;

  typedef struct packed {
    logic             led_on;
    logic             gesture_done;
    gesture_e         gesture;
    logic [HoldW-1:0] held_ms;
  } result_t;

endpackage

@@ hw/rtl/button_hold_gesture_classifier_core.sv @@
`timescale 1ns / 1ps
`include "button_hold_gesture_classifier_core_macros.svh"

// Boot-time button hold classifier. Each input beat is either a boot check
// (action 0) or a one millisecond tick (action 1) and yields exactly one
// result beat: LED level, a gesture report flag and code, and the hold time
// so far. A beat is taken every clock cycle while in_stall_o is low and its
// result is registered in the output register, or in the skid register if
// the output is stalled. All session state and the result come from one
// combinational pass from the registered state; the skid register lets one
// more beat in after the output stalls. Registers must be written by the
// user via the plain write port while no beat is in flight (not enforced).
module button_hold_gesture_classifier_core #(
  parameter int unsigned BURST_STEPS = 6
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [bhgc_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [bhgc_pkg::CfgDataW-1:0]   cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            action_i,
  input  logic                            button_pressed_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            led_on_o,
  output logic                            gesture_done_o,
  output logic [2:0]                      gesture_o,
  output logic [bhgc_pkg::HoldW-1:0]      held_ms_o
);
  import bhgc_pkg::*;

  localparam int unsigned StepW = $clog2(BURST_STEPS + 1);
  localparam logic [StepW-1:0] BurstLast = StepW'(BURST_STEPS);

  logic [HoldW-1:0]  refresh_ms_q, maintenance_ms_q, provision_ms_q;
  logic [PhaseW-1:0] pulse_half_ms_q, burst_step_ms_q;

  mode_e             mode_q, mode_d;
  logic [HoldW-1:0]  hold_q, hold_d;
  logic [PhaseW-1:0] phase_q, phase_d;
  logic              level_q, level_d;
  logic [StepW-1:0]  step_q, step_d;

  result_t           res_d, out_q, skid_q;
  logic              out_valid_q, skid_valid_q;
  logic              in_acc, out_acc;

  logic [HoldW-1:0]  hold_inc;
  logic [PhaseW:0]   phase_inc;
  logic [StepW-1:0]  step_inc;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      refresh_ms_q     <= RefreshMsRst;
      maintenance_ms_q <= MaintenanceMsRst;
      provision_ms_q   <= ProvisionMsRst;
      pulse_half_ms_q  <= PulseHalfMsRst;
      burst_step_ms_q  <= BurstStepMsRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_REFRESH_MS:     refresh_ms_q     <= cfg_data_i;
        REG_MAINTENANCE_MS: maintenance_ms_q <= cfg_data_i;
        REG_PROVISION_MS:   provision_ms_q   <= cfg_data_i;
        REG_PULSE_HALF_MS:  pulse_half_ms_q  <= cfg_data_i[PhaseW-1:0];
        REG_BURST_STEP_MS:  burst_step_ms_q  <= cfg_data_i[PhaseW-1:0];
        default: ;
      endcase
    end
  end

  assign in_stall_o = skid_valid_q;
  assign in_acc     = in_valid_i && !skid_valid_q;
  assign out_acc    = out_valid_q && !out_stall_i;

  assign hold_inc  = (hold_q == HoldMax) ? hold_q : hold_q + 1'b1;
  assign phase_inc = {1'b0, phase_q} + 1'b1;
  assign step_inc  = step_q + 1'b1;

  // next session state and result of one beat
  always_comb begin
    mode_d  = mode_q;
    hold_d  = hold_q;
    phase_d = phase_q;
    level_d = level_q;
    step_d  = step_q;
    res_d.led_on       = 1'b0;
    res_d.gesture_done = 1'b0;
    res_d.gesture      = GEST_NONE;

    if (action_i == ACT_BOOT_CHECK) begin
      hold_d  = '0;
      phase_d = '0;
      level_d = 1'b1;
      step_d  = '0;
      mode_d  = button_pressed_i ? MODE_HOLD : MODE_IDLE;
      res_d.gesture_done = !button_pressed_i;
    end else begin
      unique case (mode_q)
        MODE_HOLD: begin
          if (!button_pressed_i) begin
            mode_d = MODE_IDLE;
            res_d.gesture_done = 1'b1;
            if (hold_q >= maintenance_ms_q) begin
              res_d.gesture = GEST_MAINT;
            end else if (hold_q >= refresh_ms_q) begin
              res_d.gesture = GEST_REFRESH;
            end else begin
              res_d.gesture = GEST_TAP;
            end
          end else begin
            hold_d = hold_inc;
            if (hold_inc >= provision_ms_q) begin
              mode_d  = MODE_BURST;
              step_d  = '0;
              phase_d = '0;
              res_d.led_on = 1'b1;
            end else if (hold_inc >= maintenance_ms_q) begin
              if (hold_q >= maintenance_ms_q) begin
                if (phase_inc >= {1'b0, pulse_half_ms_q}) begin
                  phase_d = '0;
                  level_d = !level_q;
                end else begin
                  phase_d = phase_inc[PhaseW-1:0];
                end
              end else begin
                phase_d = '0;
                level_d = 1'b1;
              end
              res_d.led_on = level_d;
            end else begin
              res_d.led_on = (hold_inc >= refresh_ms_q);
            end
          end
        end
        MODE_BURST: begin
          if (phase_inc >= {1'b0, burst_step_ms_q}) begin
            phase_d = '0;
            step_d  = step_inc;
          end else begin
            phase_d = phase_inc[PhaseW-1:0];
          end
          if (step_d >= BurstLast) begin
            step_d = '0;
            mode_d = MODE_IDLE;
            res_d.gesture_done = 1'b1;
            res_d.gesture      = GEST_PROV;
          end else begin
            res_d.led_on = !step_d[0];
          end
        end
        default: ;
      endcase
    end
    res_d.held_ms = hold_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      hold_q  <= '0;
      phase_q <= '0;
      level_q <= 1'b1;
      step_q  <= '0;
    end else if (in_acc) begin
      mode_q  <= mode_d;
      hold_q  <= hold_d;
      phase_q <= phase_d;
      level_q <= level_d;
      step_q  <= step_d;
    end
  end

  // output register with skid beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_acc) begin
        skid_valid_q <= 1'b0;
      end
    end else if (in_acc) begin
      if (out_valid_q && !out_acc) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (out_acc) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_acc) begin
        out_q <= skid_q;
      end
    end else if (in_acc) begin
      if (out_valid_q && !out_acc) begin
        skid_q <= res_d;
      end else begin
        out_q <= res_d;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign led_on_o       = out_q.led_on;
  assign gesture_done_o = out_q.gesture_done;
  assign gesture_o      = out_q.gesture;
  assign held_ms_o      = out_q.held_ms;

  `BHG_ASSERT(a_skid_implies_out, skid_valid_q |-> out_valid_q, "skid beat without output beat")
  `BHG_ASSERT(a_beat_lands, in_acc |=> out_valid_q, "accepted beat produced no output")
  `BHG_ASSERT(a_gesture_needs_done, out_valid_q && !out_q.gesture_done |-> out_q.gesture == GEST_NONE, "gesture code without report")
  `BHG_ASSERT(a_step_bounded, step_q < BurstLast, "burst step past last step")

endmodule

@@ verif/tb_button_hold_gesture_classifier_core.sv @@
`timescale 1ns / 1ps

module tb_button_hold_gesture_classifier_core;
  import bhgc_pkg::*;

  localparam int unsigned BurstSteps = 6;
  localparam int unsigned NumRows    = 25;
  localparam int unsigned NumSegs    = 9;
  localparam int unsigned SegBeats   = 126;
  localparam int unsigned LongHold   = 80;
  localparam int unsigned QuietLimit = 4000;
  localparam int unsigned MaxPrinted = 40;

  typedef enum logic {
    ROW_BEAT = 1'b0,
    ROW_CFG  = 1'b1
  } row_kind_e;

  typedef struct packed {
    row_kind_e kind;
    action_e   act;
    logic      prs;
    logic      fixed;
    result_t   want;
  } stim_row_t;

  typedef struct {
    int unsigned refresh;
    int unsigned maint;
    int unsigned prov;
    int unsigned pulse_half;
    int unsigned burst_step;
  } thresholds_t;

  logic        clk_i;
  logic        rst_n     = 1'b0;
  logic        cfg_we    = 1'b0;
  logic [2:0]  cfg_idx   = '0;
  logic [15:0] cfg_data  = '0;
  logic        in_valid  = 1'b0;
  logic        action    = 1'b0;
  logic        pressed   = 1'b0;
  logic        out_stall = 1'b0;
  logic        in_stall_o;
  logic        out_valid_o;
  logic        led_on_o;
  logic        gesture_done_o;
  logic [2:0]  gesture_o;
  logic [15:0] held_ms_o;

  button_hold_gesture_classifier_core #(
    .BURST_STEPS(BurstSteps)
  ) u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall_o),
    .action_i        (action),
    .button_pressed_i(pressed),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall),
    .led_on_o        (led_on_o),
    .gesture_done_o  (gesture_done_o),
    .gesture_o       (gesture_o),
    .held_ms_o       (held_ms_o)
  );

  // session state and thresholds as the block should hold them
  thresholds_t thr;
  mode_e       ses_mode  = MODE_IDLE;
  int unsigned ses_hold  = 0;
  int unsigned ses_phase = 0;
  int unsigned ses_level = 1;
  int unsigned ses_step  = 0;

  result_t     pending_results [$];
  int unsigned mismatches    = 0;
  int unsigned counted_beats = 0;
  int unsigned quiet_cycles  = 0;
  int unsigned tx_idle_pct   = 32;
  int unsigned rx_idle_pct   = 78;
  bit          long_hold_go  = 1'b0;
  bit          paused_once   = 1'b0;

  stim_row_t dir_rows [NumRows] = '{
    '{ROW_BEAT, ACT_TICK,       1'b0, 1'b1, '{1'b0, 1'b0, GEST_NONE, 16'd0}},
    '{ROW_BEAT, ACT_TICK,       1'b1, 1'b1, '{1'b0, 1'b0, GEST_NONE, 16'd0}},
    '{ROW_BEAT, ACT_BOOT_CHECK, 1'b0, 1'b1, '{1'b0, 1'b1, GEST_NONE, 16'd0}},
    '{ROW_BEAT, ACT_BOOT_CHECK, 1'b1, 1'b1, '{1'b0, 1'b0, GEST_NONE, 16'd0}},
    '{ROW_BEAT, ACT_TICK,       1'b1, 1'b1, '{1'b0, 1'b0, GEST_NONE, 16'd1}},
    '{ROW_BEAT, ACT_BOOT_CHECK, 1'b1, 1'b1, '{1'b0, 1'b0, GEST_NONE, 16'd0}},
    '{ROW_BEAT, ACT_TICK,       1'b0, 1'b1, '{1'b0, 1'b1, GEST_TAP,  16'd0}},
    '{ROW_CFG,  ACT_TICK,       1'b0, 1'b0, '0},
    '{ROW_BEAT, ACT_BOOT_CHECK, 1'b1, 1'b0, '0},
    '{ROW_BEAT, ACT_TICK,       1'b1, 1'b0, '0},
    '{ROW_BEAT, ACT_TICK,       1'b1, 1'b0, '0},
    '{ROW_BEAT, ACT_TICK,       1'b1, 1'b0, '0},
    '{ROW_BEAT, ACT_TICK,       1'b1, 1'b0, '0},
    '{ROW_BEAT, ACT_TICK,       1'b1, 1'b0, '0},
    '{ROW_BEAT, ACT_TICK,       1'b1, 1'b0, '0},
    '{ROW_BEAT, ACT_TICK,       1'b1, 1'b0, '0},
    '{ROW_BEAT, ACT_TICK,       1'b0, 1'b0, '0},
    '{ROW_BEAT, ACT_TICK,       1'b1, 1'b0, '0},
    '{ROW_BEAT, ACT_TICK,       1'b0, 1'b0, '0},
    '{ROW_BEAT, ACT_TICK,       1'b1, 1'b0, '0},
    '{ROW_BEAT, ACT_TICK,       1'b0, 1'b0, '0},
    '{ROW_BEAT, ACT_TICK,       1'b1, 1'b1, '{1'b0, 1'b1, GEST_PROV, 16'd7}},
    '{ROW_BEAT, ACT_BOOT_CHECK, 1'b1, 1'b0, '0},
    '{ROW_BEAT, ACT_TICK,       1'b1, 1'b0, '0},
    '{ROW_BEAT, ACT_TICK,       1'b0, 1'b0, '0}
  };

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic result_t classify_beat(input action_e act, input logic prs);
    result_t     r;
    int unsigned prior;
    r = '0;
    r.gesture = GEST_NONE;
    prior = ses_hold;
    if (act == ACT_BOOT_CHECK) begin
      ses_hold  = 0;
      ses_phase = 0;
      ses_level = 1;
      ses_step  = 0;
      ses_mode  = prs ? MODE_HOLD : MODE_IDLE;
      r.gesture_done = !prs;
    end else if (ses_mode == MODE_HOLD) begin
      if (!prs) begin
        ses_mode = MODE_IDLE;
        r.gesture_done = 1'b1;
        if (ses_hold >= thr.maint) r.gesture = GEST_MAINT;
        else if (ses_hold >= thr.refresh) r.gesture = GEST_REFRESH;
        else r.gesture = GEST_TAP;
      end else begin
        if (ses_hold < HoldMax) ses_hold++;
        if (ses_hold >= thr.prov) begin
          ses_mode  = MODE_BURST;
          ses_step  = 0;
          ses_phase = 0;
          r.led_on  = 1'b1;
        end else if (ses_hold >= thr.maint) begin
          if (prior >= thr.maint) begin
            if (ses_phase + 1 >= thr.pulse_half) begin
              ses_phase = 0;
              ses_level ^= 1;
            end else begin
              ses_phase++;
            end
          end else begin
            ses_phase = 0;
            ses_level = 1;
          end
          r.led_on = ses_level[0];
        end else begin
          r.led_on = (ses_hold >= thr.refresh);
        end
      end
    end else if (ses_mode == MODE_BURST) begin
      if (ses_phase + 1 >= thr.burst_step) begin
        ses_phase = 0;
        ses_step++;
      end else begin
        ses_phase++;
      end
      if (ses_step >= BurstSteps) begin
        ses_step = 0;
        ses_mode = MODE_IDLE;
        r.gesture_done = 1'b1;
        r.gesture = GEST_PROV;
      end else begin
        r.led_on = (ses_step % 2 == 0);
      end
    end
    r.held_ms = HoldW'(ses_hold);
    return r;
  endfunction

  task automatic note_mismatch(input string what, input logic [15:0] got,
                               input logic [15:0] want);
    if (mismatches < MaxPrinted) begin
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    end
    mismatches++;
  endtask

  task automatic send_beat(input action_e act, input logic prs, input bit fixed = 1'b0,
                           input result_t want = '0);
    result_t predicted;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    action   <= act;
    pressed  <= prs;
    @(negedge clk_i);
    while (in_stall_o !== 1'b0) @(negedge clk_i);
    // taken at the coming edge
    if (!(act == ACT_TICK && ses_mode == MODE_IDLE)) counted_beats++;
    predicted = classify_beat(act, prs);
    pending_results.push_back(fixed ? want : predicted);
    @(posedge clk_i);
  endtask

  task automatic settle_block();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic load_thresholds(input thresholds_t t);
    cfg_we   <= 1'b1;
    cfg_idx  <= REG_REFRESH_MS;
    cfg_data <= 16'(t.refresh);
    @(posedge clk_i);
    cfg_idx  <= REG_MAINTENANCE_MS;
    cfg_data <= 16'(t.maint);
    @(posedge clk_i);
    cfg_idx  <= REG_PROVISION_MS;
    cfg_data <= 16'(t.prov);
    @(posedge clk_i);
    cfg_idx  <= REG_PULSE_HALF_MS;
    cfg_data <= 16'(t.pulse_half);
    @(posedge clk_i);
    cfg_idx  <= REG_BURST_STEP_MS;
    cfg_data <= 16'(t.burst_step);
    @(posedge clk_i);
    cfg_we   <= 1'b0;
    thr = t;
  endtask

  task automatic play_session();
    int unsigned pick;
    int unsigned span;
    int unsigned n;
    pick = $urandom_range(99);
    if (pick < 75) begin
      span = thr.prov + BurstSteps * thr.burst_step + 3;
      if (span > 120) span = 120;
      n = $urandom_range(span);
      send_beat(ACT_BOOT_CHECK, 1'b1);
      repeat (n) begin
        send_beat(ACT_TICK, (ses_mode == MODE_BURST) ? 1'($urandom_range(1)) : 1'b1);
      end
      if ($urandom_range(9) < 7) send_beat(ACT_TICK, 1'b0);
      else send_beat(ACT_BOOT_CHECK, 1'($urandom_range(1)));
    end else if (pick < 85) begin
      send_beat(ACT_BOOT_CHECK, 1'b0);
    end else begin
      repeat ($urandom_range(1, 6)) begin
        send_beat(action_e'($urandom_range(1)), 1'($urandom_range(1)));
      end
    end
  endtask

  // result side back-pressure
  always @(posedge clk_i) begin : drive_stall
    int unsigned hold_left;
    bit          hold_done;
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (long_hold_go && !hold_done) begin
      hold_done = 1'b1;
      hold_left = LongHold - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  always @(negedge clk_i) begin : watch_results
    result_t want;
    if (rst_n && out_valid_o === 1'b1 && out_stall === 1'b0) begin
      if (pending_results.size() == 0) begin
        note_mismatch("result beat with nothing pending", held_ms_o, '0);
      end else begin
        want = pending_results.pop_front();
        if (led_on_o !== want.led_on) begin
          note_mismatch("led_on", 16'(led_on_o), 16'(want.led_on));
        end
        if (gesture_done_o !== want.gesture_done) begin
          note_mismatch("gesture_done", 16'(gesture_done_o), 16'(want.gesture_done));
        end
        if (gesture_o !== want.gesture) begin
          note_mismatch("gesture", 16'(gesture_o), 16'(want.gesture));
        end
        if (held_ms_o !== want.held_ms) note_mismatch("held_ms", held_ms_o, want.held_ms);
      end
    end
  end

  always @(negedge clk_i) begin
    if ((in_valid && in_stall_o === 1'b0) || (out_valid_o === 1'b1 && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("** button_hold_gesture_classifier_core: FAILED **");
      $finish;
    end
  end

  initial begin
    thresholds_t t;
    int unsigned seg_goal;
    thr = '{32'(RefreshMsRst), 32'(MaintenanceMsRst), 32'(ProvisionMsRst),
            32'(PulseHalfMsRst), 32'(BurstStepMsRst)};
    repeat (7) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        settle_block();
        // one tick per burst step, pulse toggling every tick
        t = '{1, 3, 7, 0, 0};
        load_thresholds(t);
      end else begin
        send_beat(dir_rows[i].act, dir_rows[i].prs, dir_rows[i].fixed, dir_rows[i].want);
      end
    end

    for (int seg = 0; seg < NumSegs; seg++) begin
      settle_block();
      t = '{$urandom_range(20), $urandom_range(30), $urandom_range(1, 60),
            $urandom_range(1, 6), $urandom_range(1, 4)};
      case (seg)
        1: t = '{0, 0, 65535, 1, 1};
        4: t = '{65535, 65535, 0, 4095, 4095};
        7: t = '{$urandom_range(10, 30), $urandom_range(9), $urandom_range(15, 45), 0, 0};
        default: ;
      endcase
      load_thresholds(t);
      tx_idle_pct = (seg < 3) ? 32 : (seg < 6) ? 78 : 0;
      rx_idle_pct = (seg < 3) ? 78 : (seg < 6) ? 32 : 0;
      if (seg == 6) long_hold_go = 1'b1;
      seg_goal = counted_beats + SegBeats;
      while (counted_beats < seg_goal) begin
        play_session();
        if (seg == 6 && !paused_once && counted_beats + 60 >= seg_goal) begin
          settle_block();
          paused_once = 1'b1;
        end
      end
    end

    settle_block();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("** button_hold_gesture_classifier_core: PASSED **");
    end else begin
      $display("** button_hold_gesture_classifier_core: FAILED **");
    end
    $finish;
  end

endmodule
